/* src/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* src/ttrr_pkg.sv */
// Types and codes for the thread table scheduler.
// No dependencies.
package ttrr_pkg;

  typedef enum logic [1:0] {
    SLOT_DEAD     = 2'd0,
    SLOT_RUNNABLE = 2'd1,
    SLOT_RUNNING  = 2'd2
  } slot_t;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_YIELD  = 2'd1,
    REQ_EXIT   = 2'd2,
    REQ_JOIN   = 2'd3
  } req_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FAIL = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;

  typedef struct packed {
    logic  state_en;
    slot_t state;
    logic  join_en;
    logic  jvalid;
  } wr_ctl_t;

endpackage

/* src/ttrr_table.sv */
// Thread slot table: state, joiner valid and joiner per slot.
// One read address, one write address per cycle. Depends on ttrr_pkg.
module ttrr_table #(
  parameter int THREADS = 16,
  parameter int IDX_W   = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IDX_W-1:0]      rd_idx,
  output ttrr_pkg::slot_t       rd_state,
  output logic                  rd_jvalid,
  output logic [IDX_W-1:0]      rd_joiner,
  input  logic [IDX_W-1:0]      wr_idx,
  input  ttrr_pkg::wr_ctl_t     wr_ctl,
  input  logic [IDX_W-1:0]      wr_joiner
);
  import ttrr_pkg::*;

  slot_t            state  [THREADS];
  logic             jvalid [THREADS];
  logic [IDX_W-1:0] joiner [THREADS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREADS; i++) begin
        state[i]  <= (i == 0) ? SLOT_RUNNING : SLOT_DEAD;
        jvalid[i] <= 1'b0;
      end
    end else begin
      if (wr_ctl.state_en) state[wr_idx] <= wr_ctl.state;
      if (wr_ctl.join_en) jvalid[wr_idx] <= wr_ctl.jvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.join_en) joiner[wr_idx] <= wr_joiner;
  end

  assign rd_state  = state[rd_idx];
  assign rd_jvalid = jvalid[rd_idx];
  assign rd_joiner = joiner[rd_idx];

endmodule

/* src/thread_table_round_robin_scheduler.sv */
// Top level of the round-robin thread scheduler with join.
// Depends on ttrr_pkg and ttrr_table.
//
//  channel | signals                          | dir
//  --------+----------------------------------+-----
//  request | in_valid in_ready req_type target | in
//  result  | out_valid out_ready status        | out
//          | thread_id running                 |
//
// One word in flight at a time; the table is reached one slot per cycle.
// Create scans for the first dead slot; join checks the target, then writes the joiner link;
// exit/yield run a joiner pass, then a round-robin pass; a failed join or exit stops at its check.
// Reset leaves slot 0 running and all other slots dead; in_ready rises as soon as rst falls.
// The result register holds until taken; the next word may be accepted meanwhile.
module thread_table_round_robin_scheduler #(
  parameter int THREADS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [3:0] target,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [3:0] thread_id,
  output logic [3:0] running
);
  import ttrr_pkg::*;

  localparam int IDX_W = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int CW    = ((IDX_W > 4) ? IDX_W : 4) + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(THREADS - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FREE  = 7'b0000010,
    S_MARK  = 7'b0000100,
    S_CHECK = 7'b0001000,
    S_MASK  = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_FIX   = 7'b1000000
  } fsm_t;

  fsm_t             fsm, fsm_next;
  req_t             req, req_next;
  logic [3:0]       tgt, tgt_next;
  logic [IDX_W-1:0] cur, cur_next;
  logic [IDX_W-1:0] n, n_next;
  logic [IDX_W-1:0] k, k_next;
  logic [THREADS-1:0] blocked, blocked_next;
  logic             done, done_next;
  logic [1:0]       stat, stat_next;
  logic [IDX_W-1:0] tid, tid_next;

  logic [IDX_W-1:0] rd_idx, wr_idx, wr_joiner, rd_joiner;
  slot_t            rd_state;
  logic             rd_jvalid;
  wr_ctl_t          wr_ctl;
  logic             tgt_bad;
  logic             out_free;

  ttrr_table #(.THREADS(THREADS), .IDX_W(IDX_W)) u_table (
    .clk       (clk),
    .rst       (rst),
    .rd_idx    (rd_idx),
    .rd_state  (rd_state),
    .rd_jvalid (rd_jvalid),
    .rd_joiner (rd_joiner),
    .wr_idx    (wr_idx),
    .wr_ctl    (wr_ctl),
    .wr_joiner (wr_joiner)
  );

  assign tgt_bad  = CW'(tgt) >= CW'(THREADS);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (fsm == S_IDLE) && !done && !rst;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
    return (v == LAST) ? '0 : v + 1'b1;
  endfunction

  always_comb begin
    fsm_next     = fsm;
    req_next     = req;
    tgt_next     = tgt;
    cur_next     = cur;
    n_next       = n;
    k_next       = k;
    blocked_next = blocked;
    done_next    = done;
    stat_next    = stat;
    tid_next     = tid;
    rd_idx       = n;
    wr_idx       = cur;
    wr_joiner    = '0;
    wr_ctl       = '{state_en: 1'b0, state: SLOT_DEAD, join_en: 1'b0, jvalid: 1'b0};

    if (done && out_free) done_next = 1'b0;

    unique case (fsm)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req_next = req_t'(req_type);
          tgt_next = target;
          n_next   = '0;
          unique case (req_t'(req_type))
            REQ_CREATE: fsm_next = S_FREE;
            REQ_YIELD:  fsm_next = S_MARK;
            REQ_EXIT,
            REQ_JOIN:   fsm_next = S_CHECK;
            default:    fsm_next = S_IDLE;
          endcase
        end
      end
      S_FREE: begin
        rd_idx = n;
        if (rd_state == SLOT_DEAD) begin
          wr_idx    = n;
          wr_ctl    = '{state_en: 1'b1, state: SLOT_RUNNABLE, join_en: 1'b1, jvalid: 1'b0};
          stat_next = STAT_OK;
          tid_next  = n;
          done_next = 1'b1;
          fsm_next  = S_IDLE;
        end else if (n == LAST) begin
          stat_next = STAT_FAIL;
          tid_next  = cur;
          done_next = 1'b1;
          fsm_next  = S_IDLE;
        end else begin
          n_next = n + 1'b1;
        end
      end
      S_MARK: begin
        wr_idx       = cur;
        wr_ctl       = '{state_en: 1'b1, state: SLOT_RUNNABLE, join_en: 1'b0, jvalid: 1'b0};
        n_next       = '0;
        blocked_next = '0;
        fsm_next     = S_MASK;
      end
      S_CHECK: begin
        if (req == REQ_JOIN) begin
          rd_idx = IDX_W'(tgt);
          if (tgt_bad || rd_state != SLOT_RUNNABLE) begin
            stat_next = STAT_FAIL;
            tid_next  = cur;
            done_next = 1'b1;
            fsm_next  = S_IDLE;
          end else begin
            wr_idx   = cur;
            wr_ctl   = '{state_en: 1'b1, state: SLOT_RUNNABLE, join_en: 1'b0, jvalid: 1'b0};
            fsm_next = S_FIX;
          end
        end else begin
          rd_idx = cur;
          if (rd_state == SLOT_DEAD) begin
            stat_next = STAT_FAIL;
            tid_next  = cur;
            done_next = 1'b1;
            fsm_next  = S_IDLE;
          end else begin
            wr_idx       = cur;
            wr_ctl       = '{state_en: 1'b1, state: SLOT_DEAD, join_en: 1'b1, jvalid: 1'b0};
            n_next       = '0;
            blocked_next = '0;
            fsm_next     = S_MASK;
          end
        end
      end
      S_MASK: begin
        rd_idx = n;
        if (rd_jvalid) blocked_next[rd_joiner] = 1'b1;
        if (n == LAST) begin
          n_next   = '0;
          k_next   = wrap_inc(cur);
          fsm_next = S_SCAN;
        end else begin
          n_next = n + 1'b1;
        end
      end
      S_SCAN: begin
        rd_idx = k;
        if (rd_state == SLOT_RUNNABLE && !blocked[k]) begin
          wr_idx    = k;
          wr_ctl    = '{state_en: 1'b1, state: SLOT_RUNNING, join_en: 1'b0, jvalid: 1'b0};
          cur_next  = k;
          stat_next = STAT_OK;
          tid_next  = k;
          done_next = 1'b1;
          fsm_next  = S_IDLE;
        end else if (n == LAST) begin
          if (req == REQ_YIELD) begin
            wr_idx = cur;
            wr_ctl = '{state_en: 1'b1, state: SLOT_RUNNING, join_en: 1'b0, jvalid: 1'b0};
          end
          stat_next = STAT_NONE;
          tid_next  = cur;
          done_next = 1'b1;
          fsm_next  = S_IDLE;
        end else begin
          n_next = n + 1'b1;
          k_next = wrap_inc(k);
        end
      end
      S_FIX: begin
        wr_idx    = IDX_W'(tgt);
        wr_ctl    = '{state_en: 1'b1, state: SLOT_RUNNING, join_en: 1'b1, jvalid: 1'b1};
        wr_joiner = cur;
        cur_next  = IDX_W'(tgt);
        stat_next = STAT_OK;
        tid_next  = IDX_W'(tgt);
        done_next = 1'b1;
        fsm_next  = S_IDLE;
      end
      default: fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= S_IDLE;
      cur       <= '0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fsm  <= fsm_next;
      cur  <= cur_next;
      done <= done_next;
      if (done && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    req     <= req_next;
    tgt     <= tgt_next;
    n       <= n_next;
    k       <= k_next;
    blocked <= blocked_next;
    stat    <= stat_next;
    tid     <= tid_next;
    if (done && out_free) begin
      status    <= stat;
      thread_id <= 4'(tid);
      running   <= 4'(cur);
    end
  end

endmodule

/* src/ttrr_checker.sv */
// Port-level checks for the thread table scheduler, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ttrr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] req_type,
  input logic [3:0] target,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [3:0] thread_id,
  input logic [3:0] running
);

  `ASSERT_IMP(a_status_code, clk, rst, out_valid, status != 2'd3, "status code out of range")

  `ASSERT_IMP(a_tid_running, clk, rst, out_valid && status != 2'd0, thread_id == running,
    "failed or idle word must report the running slot")

  `ASSERT_NXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready,
    "request taken while another is in progress")

  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(thread_id) && $stable(running),
    "result word changed while stalled")

endmodule

bind thread_table_round_robin_scheduler ttrr_checker u_ttrr_checker (.*);

/* sim/tb.sv */
// Self-checking bench for thread_table_round_robin_scheduler: directed table then random
// request mix, each result word checked against a typed row or an in-bench slot table predictor.
// Depends on ttrr_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb;
  import ttrr_pkg::*;

  localparam int NSLOTS      = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int WDOG_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [1:0] stat;
    logic [3:0] tid;
    logic [3:0] run;
  } sched_res_t;

  typedef struct {
    req_t       rq;
    logic [3:0] tg;
    bit         typed;
    sched_res_t res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] req_type;
  logic [3:0] target;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] status;
  logic [3:0] thread_id;
  logic [3:0] running;

  // predicted slot table
  slot_t      slot_st [NSLOTS];
  bit         join_vld[NSLOTS];
  logic [3:0] join_id [NSLOTS];
  logic [3:0] cur_slot;

  sched_res_t sched_q[$];
  dir_row_t   dir_tab[$];
  int         mismatch_cnt = 0;
  int         quiet_cnt = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  bit         long_hold = 1'b0;

  always #2 clk = ~clk;

  thread_table_round_robin_scheduler #(.THREADS(NSLOTS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .target    (target),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .thread_id (thread_id),
    .running   (running)
  );

  function automatic void table_reset();
    for (int k = 0; k < NSLOTS; k++) begin
      slot_st[k]  = SLOT_DEAD;
      join_vld[k] = 1'b0;
      join_id[k]  = '0;
    end
    slot_st[0] = SLOT_RUNNING;
    cur_slot   = '0;
  endfunction

  function automatic bit slot_eligible(int k);
    if (slot_st[k] != SLOT_RUNNABLE) return 1'b0;
    for (int f = 0; f < NSLOTS; f++)
      if (join_vld[f] && join_id[f] == 4'(k)) return 1'b0;
    return 1'b1;
  endfunction

  // round-robin scan from the slot after current, ending with current itself
  function automatic bit next_eligible(output logic [3:0] found);
    logic [3:0] k;
    k = cur_slot + 4'd1;
    found = '0;
    for (int n = 0; n < NSLOTS; n++) begin
      if (slot_eligible(int'(k))) begin
        found = k;
        return 1'b1;
      end
      k = k + 4'd1;
    end
    return 1'b0;
  endfunction

  function automatic sched_res_t schedule_request(req_t rq, logic [3:0] tg);
    sched_res_t r;
    logic [3:0] k;
    bit         got;
    r.stat = STAT_OK;
    r.tid  = cur_slot;
    got    = 1'b0;
    k      = '0;
    case (rq)
      REQ_CREATE: begin
        for (int i = NSLOTS - 1; i >= 0; i--)
          if (slot_st[i] == SLOT_DEAD) begin
            got = 1'b1;
            k   = 4'(i);
          end
        if (got) begin
          slot_st[k]  = SLOT_RUNNABLE;
          join_vld[k] = 1'b0;
          join_id[k]  = '0;
          r.tid       = k;
        end else begin
          r.stat = STAT_FAIL;
        end
      end
      REQ_YIELD: begin
        slot_st[cur_slot] = SLOT_RUNNABLE;
        if (next_eligible(k)) cur_slot = k;
        else r.stat = STAT_NONE;
        slot_st[cur_slot] = SLOT_RUNNING;
        r.tid = cur_slot;
      end
      REQ_EXIT: begin
        if (slot_st[cur_slot] == SLOT_DEAD) begin
          r.stat = STAT_FAIL;
        end else begin
          slot_st[cur_slot]  = SLOT_DEAD;
          join_vld[cur_slot] = 1'b0;
          join_id[cur_slot]  = '0;
          if (next_eligible(k)) begin
            cur_slot          = k;
            slot_st[cur_slot] = SLOT_RUNNING;
          end else begin
            r.stat = STAT_NONE;
          end
        end
        r.tid = cur_slot;
      end
      default: begin
        if (slot_st[tg] != SLOT_RUNNABLE) begin
          r.stat = STAT_FAIL;
        end else begin
          slot_st[cur_slot] = SLOT_RUNNABLE;
          join_vld[tg]      = 1'b1;
          join_id[tg]       = cur_slot;
          cur_slot          = tg;
          slot_st[tg]       = SLOT_RUNNING;
        end
        r.tid = cur_slot;
      end
    endcase
    r.run = cur_slot;
    return r;
  endfunction

  function automatic void add_row(req_t rq, logic [3:0] tg, bit typed, logic [1:0] st,
                                  logic [3:0] tid, logic [3:0] run);
    dir_row_t row;
    row.rq      = rq;
    row.tg      = tg;
    row.typed   = typed;
    row.res.stat = st;
    row.res.tid  = tid;
    row.res.run  = run;
    dir_tab.push_back(row);
  endfunction

  task automatic send_req(req_t rq, logic [3:0] tg, bit typed, sched_res_t typed_res);
    sched_res_t p;
    in_valid <= 1'b1;
    req_type <= rq;
    target   <= tg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = schedule_request(rq, tg);
    sched_q.push_back(typed ? typed_res : p);
  endtask

  task automatic idle_in(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // grow favours create, shrink favours exit; joins mostly aim at runnable slots
  task automatic pick_req(bit grow, output req_t rq, output logic [3:0] tg);
    int         roll;
    logic [3:0] pool[$];
    roll = $urandom_range(99);
    tg   = 4'($urandom_range(15));
    if (roll < (grow ? 40 : 10)) rq = REQ_CREATE;
    else if (roll < (grow ? 65 : 35)) rq = REQ_YIELD;
    else if (roll < 75) rq = REQ_EXIT;
    else rq = REQ_JOIN;
    if (rq == REQ_JOIN) begin
      for (int k = 0; k < NSLOTS; k++)
        if (slot_st[k] == SLOT_RUNNABLE) pool.push_back(4'(k));
      if (pool.size() != 0 && $urandom_range(99) < 75)
        tg = pool[$urandom_range(pool.size() - 1)];
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    sched_res_t exp_r;
    sched_res_t got_r;
    if (!rst && out_valid && out_ready) begin
      got_r.stat = status;
      got_r.tid  = thread_id;
      got_r.run  = running;
      if (sched_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result word: status %0d id %0d run %0d",
                   got_r.stat, got_r.tid, got_r.run);
      end else begin
        exp_r = sched_q.pop_front();
        if (got_r.stat !== exp_r.stat || got_r.tid !== exp_r.tid ||
            got_r.run !== exp_r.run) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp status %0d id %0d run %0d, got status %0d id %0d run %0d",
                     exp_r.stat, exp_r.tid, exp_r.run, got_r.stat, got_r.tid, got_r.run);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt == WDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    req_t       rq;
    logic [3:0] tg;
    rst      = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_CREATE;
    target   = '0;
    table_reset();

    // directed: lone slot, dead current, full table, join chain
    add_row(REQ_YIELD,  4'd0,  1'b1, STAT_OK,   4'd0, 4'd0);
    add_row(REQ_EXIT,   4'd0,  1'b1, STAT_NONE, 4'd0, 4'd0);
    add_row(REQ_EXIT,   4'd0,  1'b1, STAT_FAIL, 4'd0, 4'd0);
    add_row(REQ_JOIN,   4'd5,  1'b1, STAT_FAIL, 4'd0, 4'd0);
    add_row(REQ_YIELD,  4'd0,  1'b0, STAT_OK,   4'd0, 4'd0);
    for (int i = 1; i < NSLOTS; i++)
      add_row(REQ_CREATE, 4'(i), 1'b1, STAT_OK, 4'(i), 4'd0);
    add_row(REQ_CREATE, 4'd15, 1'b1, STAT_FAIL, 4'd0, 4'd0);
    add_row(REQ_JOIN,   4'd15, 1'b0, STAT_OK,   4'd0, 4'd0);
    add_row(REQ_JOIN,   4'd0,  1'b0, STAT_OK,   4'd0, 4'd0);
    add_row(REQ_YIELD,  4'd0,  1'b0, STAT_OK,   4'd0, 4'd0);
    add_row(REQ_EXIT,   4'd0,  1'b0, STAT_OK,   4'd0, 4'd0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send_req(dir_tab[i].rq, dir_tab[i].tg, dir_tab[i].typed, dir_tab[i].res);

    // phases: no idling, sender gaps with one long receiver hold, receiver stalls, both lightly
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = (ph == 1) ? 62 : (ph == 3) ? 13 : 0;
      stall_pct = (ph == 2) ? 62 : (ph == 3) ? 13 : 0;
      if (ph == 1) begin
        long_hold = 1'b1;
        repeat (6) begin
          pick_req(1'b1, rq, tg);
          send_req(rq, tg, 1'b0, '0);
        end
      end
      for (int n = 0; n < 112; n++) begin
        if ($urandom_range(99) < gap_pct) idle_in($urandom_range(1, 40));
        pick_req(((n / 32) % 2) == 0, rq, tg);
        send_req(rq, tg, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
